// ----- hdl/hhc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, fixed-point constants and elaboration-time table functions
// for the Hamming high-pass coefficient generator. No dependencies.
package hhc_pkg;

  // Default filter length
  localparam int TAPS_DEFAULT = 63;

  // Reset value of the sample-rate register
  localparam logic [17:0] FS_RESET = 18'd44100;

  // Q2.30 one and the constant pi in Q2.30 (truncated)
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Hamming window terms 0.54 and 0.46 in Q2.30
  localparam logic [63:0] W_A_Q30 = 64'd579820585;
  localparam logic [63:0] W_B_Q30 = 64'd493921239;

  // Quotient bits of the normalized-cutoff division
  localparam int FC_QBITS = 30;

  // Tap divider: quotient bits, divisor width, numerator width
  localparam int DIV_QBITS = 30;
  localparam int DIV_DW = 37;
  localparam int NUM_W = 62;

  // Taylor series steps; divide by 110, 72, 42, 20, 6 as exact reciprocal multiply
  // for 32-bit dividends: floor(y / d) = (y * m) >> s, m = ceil(2^s / d)
  localparam int HSTEPS = 5;
  localparam int HORNER_SHIFT [HSTEPS] = '{39, 39, 38, 37, 35};
  localparam logic [32:0] HORNER_MAGIC [HSTEPS] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  // Per-tap data that travels alongside the arithmetic pipeline
  typedef struct packed {
    logic [5:0]  n;
    logic        last;
    logic        centre;
    logic [5:0]  k;
    logic [30:0] hc;
    logic [30:0] win;
    logic        neg;
  } tap_side_t;

  // Sine of a 32-bit phase, Q2.30 two's complement; used only on constants
  function automatic logic [63:0] fx_sin_c(input logic [31:0] p);
    logic         neg;
    logic [63:0]  a;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  t;
    logic [63:0]  s;
    logic [127:0] y;
    neg = p[31];
    a = neg ? (64'h1_0000_0000 - 64'(p)) : 64'(p);
    if (a > 64'h4000_0000) begin
      a = 64'h8000_0000 - a;
    end
    x = (a * 64'(PI_Q30)) >> 31;
    x2 = (x * x) >> 30;
    t = 64'(ONE_Q30);
    for (int j = 0; j < HSTEPS; j++) begin
      y = 128'((x2 * t) >> 30) * 128'(HORNER_MAGIC[j]);
      t = 64'(ONE_Q30) - 64'(y >> HORNER_SHIFT[j]);
    end
    s = (x * t) >> 30;
    return neg ? (64'd0 - s) : s;
  endfunction

  // Hamming window value for a cosine phase, Q2.30 (always positive)
  function automatic logic [30:0] win_of_phase(input logic [31:0] p);
    logic [63:0] c;
    logic [63:0] cm;
    logic [63:0] cw;
    logic [63:0] w;
    c = fx_sin_c(p);
    cm = c[63] ? (64'd0 - c) : c;
    cw = (cm * W_B_Q30 + (64'd1 << 29)) >> 30;
    w = c[63] ? (W_A_Q30 + cw) : (W_A_Q30 - cw);
    return w[30:0];
  endfunction

endpackage

// ----- hdl/hhc_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: cutoff words in, coefficient words out.
// No dependencies.
interface hhc_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] cutoff_hz;
  modport source (output valid, output cutoff_hz, input ready);
  modport sink (input valid, input cutoff_hz, output ready);
endinterface

interface hhc_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         tap_index;
  logic signed [15:0] coefficient;
  logic               last_tap;
  modport source (output valid, output tap_index, output coefficient, output last_tap,
                  input ready);
  modport sink (input valid, input tap_index, input coefficient, input last_tap,
                output ready);
endinterface

// ----- hdl/hamming_highpass_coefficient_generator.sv -----
`timescale 1ns / 1ps
// Hamming-windowed sinc high-pass coefficient generator, top level.
// Depends on hhc_pkg, hhc_if, hhc_fc_unit, hhc_sine_pipe, hhc_div_pipe, hhc_scale.
//
// Usage:
//   cutoff_ch takes one cutoff frequency word in Hz (valid/ready). For each
//   cutoff, tap_ch returns TAPS words (tap_index, Q1.15 coefficient,
//   last_tap on the final one), in tap order 0 .. TAPS-1.
//   cfg_wr_en/cfg_wr_data write the sample rate in Hz; write only while idle.
//   Pipeline: the cutoff division is skipped when the cutoff is at or
//   above half the sample rate, or the rate is zero; each coefficient
//   then passes through the tap pipeline (14 sine stages, 30 divider
//   stages, 3 scale stages and issue stages).
//   Throughput: one coefficient per cycle while tap_ch is not stalled;
//   the cutoff division for the next word runs while the current set is
//   issued, and the next set can start right after the last tap.
//   Reset (rst, synchronous) empties the pipeline and sets the sample rate
//   to 44100 Hz. When tap_ch is stalled the whole pipeline holds; no word is
//   lost or repeated.
module hamming_highpass_coefficient_generator #(
  parameter int TAPS = hhc_pkg::TAPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [17:0] cfg_wr_data,
  hhc_in_if.sink      cutoff_ch,
  hhc_out_if.source   tap_ch
);
  import hhc_pkg::*;

  localparam logic [5:0] NLast = 6'(TAPS - 1);
  localparam logic [5:0] Centre = 6'((TAPS - 1) / 2);

  logic [17:0] fs_hz;
  logic        fc_valid;
  logic [30:0] fc;
  logic        fc_take;
  logic        en;

  logic        active;
  logic [5:0]  n;
  logic [30:0] fc_hold;

  logic [30:0] win_tab [TAPS];
  logic [5:0]  k_cur;
  tap_side_t   side_cur;
  logic [36:0] ph_prod;

  logic        p_valid;
  tap_side_t   p_side;
  logic [31:0] p_phase;

  logic        s_valid;
  logic [30:0] s_mag;
  tap_side_t   s_side;

  logic [DIV_DW-1:0] d_cur;
  logic              d_valid;
  tap_side_t         d_side;
  logic [NUM_W-1:0]  d_num;
  logic [DIV_DW-1:0] d_den;

  logic                 q_valid;
  logic [DIV_QBITS-1:0] q_quot;
  tap_side_t            q_side;

  // Window table, built at elaboration from the cosine phase of each tap
  for (genvar gi = 0; gi < TAPS; gi++) begin : g_win
    localparam logic [63:0] WpRaw = ((64'(gi) << 32) + 64'((TAPS - 1) / 2)) / 64'(TAPS - 1);
    localparam logic [31:0] Wp = 32'(WpRaw + 64'h4000_0000);
    localparam logic [30:0] Wv = win_of_phase(Wp);
    assign win_tab[gi] = Wv;
  end

  // Sample-rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_hz <= FS_RESET;
    end else if (cfg_wr_en) begin
      fs_hz <= cfg_wr_data;
    end
  end

  hhc_fc_unit u_fc (
    .clk         (clk),
    .rst         (rst),
    .cutoff_ch   (cutoff_ch),
    .fs_hz       (fs_hz),
    .fc_take     (fc_take),
    .fc_valid    (fc_valid),
    .fc          (fc)
  );

  // Load the next cutoff when idle or on the last tap of the current set
  assign fc_take = en && fc_valid && (!active || (n == NLast));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      n <= '0;
    end else if (en) begin
      if (active && (n != NLast)) begin
        n <= n + 1'b1;
      end else if (fc_valid) begin
        active <= 1'b1;
        n <= '0;
      end else begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fc_take) begin
      fc_hold <= fc;
    end
  end

  // Build tap info and the sine phase k*fc*2
  always_comb begin
    k_cur = (n > Centre) ? (n - Centre) : (Centre - n);
    side_cur.n = n;
    side_cur.last = (n == NLast);
    side_cur.centre = (n == Centre);
    side_cur.k = k_cur;
    side_cur.hc = ONE_Q30 - fc_hold;
    side_cur.win = win_tab[n];
    side_cur.neg = 1'b0;
    ph_prod = 37'(k_cur) * 37'(fc_hold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= side_cur;
      p_phase <= {ph_prod[30:0], 1'b0};
    end
  end

  hhc_sine_pipe u_sine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .phase     (p_phase),
    .in_side   (p_side),
    .out_valid (s_valid),
    .sin_mag   (s_mag),
    .out_side  (s_side)
  );

  // Divisor pi*k and rounded numerator |sin|*2^30 + divisor/2
  assign d_cur = DIV_DW'(DIV_DW'(s_side.k) * DIV_DW'(PI_Q30));

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side <= s_side;
      d_num <= {1'b0, s_mag, 30'd0} + NUM_W'(d_cur >> 1);
      d_den <= d_cur;
    end
  end

  hhc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .num       (d_num),
    .den       (d_den),
    .in_side   (d_side),
    .out_valid (q_valid),
    .quot      (q_quot),
    .out_side  (q_side)
  );

  hhc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_side  (q_side),
    .quot     (q_quot),
    .tap_ch   (tap_ch),
    .advance  (en)
  );

endmodule

// ----- hdl/hhc_fc_unit.sv -----
`timescale 1ns / 1ps
// Normalized cutoff fc = round(2*cutoff*2^30 / fs), one quotient bit a cycle.
// Depends on hhc_pkg and hhc_in_if.
module hhc_fc_unit (
  input  logic        clk,
  input  logic        rst,
  hhc_in_if.sink      cutoff_ch,
  input  logic [17:0] fs_hz,
  input  logic        fc_take,
  output logic        fc_valid,
  output logic [30:0] fc
);
  import hhc_pkg::*;

  localparam int CntW = $clog2(FC_QBITS);

  logic                busy;
  logic [CntW-1:0]     cnt;
  logic [17:0]         rem;
  logic [17:0]         divisor;
  logic [FC_QBITS-1:0] low;
  logic [FC_QBITS-1:0] quo;
  logic [17:0]         cut2;
  logic [18:0]         shifted;
  logic                qbit;
  logic [17:0]         rem_next;

  // One restoring division step
  always_comb begin
    cut2 = {cutoff_ch.cutoff_hz, 1'b0};
    shifted = {rem, low[FC_QBITS-1]};
    qbit = shifted >= {1'b0, divisor};
    rem_next = qbit ? 18'(shifted - {1'b0, divisor}) : shifted[17:0];
  end

  assign cutoff_ch.ready = !busy && !fc_valid;

  // Accept a cutoff, iterate, hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fc_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cutoff_ch.valid && cutoff_ch.ready) begin
        if (fs_hz == 18'd0) begin
          fc <= '0;
          fc_valid <= 1'b1;
        end else if (cut2 >= fs_hz) begin
          fc <= ONE_Q30;
          fc_valid <= 1'b1;
        end else begin
          rem <= cut2;
          low <= FC_QBITS'(fs_hz >> 1);
          divisor <= fs_hz;
          cnt <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        low <= low << 1;
        quo <= {quo[FC_QBITS-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(FC_QBITS - 1)) begin
          busy <= 1'b0;
          fc_valid <= 1'b1;
          fc <= 31'({quo[FC_QBITS-2:0], qbit});
        end
      end else if (fc_take) begin
        fc_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/hhc_sine_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined fixed-point sine magnitude: fold, scale to radians, Taylor series.
// Depends on hhc_pkg.
module hhc_sine_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       phase,
  input  hhc_pkg::tap_side_t in_side,
  output logic              out_valid,
  output logic [30:0]       sin_mag,
  output hhc_pkg::tap_side_t out_side
);
  import hhc_pkg::*;

  typedef struct packed {
    tap_side_t   side;
    logic [30:0] x;
    logic [31:0] x2;
  } sine_carry_t;

  logic        f_valid;
  tap_side_t   f_side;
  logic [30:0] f_a;
  logic        x_valid;
  tap_side_t   x_side;
  logic [30:0] x_x;
  logic        c_valid;
  sine_carry_t c_carry;

  logic [31:0] a1;
  logic [31:0] a2;
  tap_side_t   side_fold;
  logic [62:0] x_prod;
  logic [61:0] x2_prod;
  logic [61:0] s_prod;

  logic        a_valid [HSTEPS];
  sine_carry_t a_carry [HSTEPS];
  logic [31:0] a_y [HSTEPS];
  logic        b_valid [HSTEPS];
  sine_carry_t b_carry [HSTEPS];
  logic [30:0] b_t [HSTEPS];

  // Fold phase into a quarter turn and note the sign
  always_comb begin
    a1 = phase[31] ? (32'd0 - phase) : phase;
    a2 = (a1 > 32'h4000_0000) ? (32'h8000_0000 - a1) : a1;
    side_fold = in_side;
    side_fold.neg = phase[31];
    x_prod = 63'(f_a) * 63'(PI_Q30);
    x2_prod = 62'(x_x) * 62'(x_x);
    s_prod = 62'(b_carry[HSTEPS-1].x) * 62'(b_t[HSTEPS-1]);
  end

  // Valid bits of the front stages and the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      x_valid <= 1'b0;
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_valid <= in_valid;
      x_valid <= f_valid;
      c_valid <= x_valid;
      out_valid <= b_valid[HSTEPS-1];
    end
  end

  // Front data: fold, radians, square; back: final multiply
  always_ff @(posedge clk) begin
    if (en) begin
      f_a <= a2[30:0];
      f_side <= side_fold;
      x_x <= x_prod[61:31];
      x_side <= f_side;
      c_carry.side <= x_side;
      c_carry.x <= x_x;
      c_carry.x2 <= x2_prod[61:30];
      sin_mag <= s_prod[60:30];
      out_side <= b_carry[HSTEPS-1].side;
    end
  end

  // Horner steps: multiply, then divide by reciprocal and subtract from one
  for (genvar j = 0; j < HSTEPS; j++) begin : g_horner
    logic        v_in;
    sine_carry_t c_in;
    logic [30:0] t_in;
    logic [62:0] y_prod;
    logic [64:0] m_prod;

    if (j == 0) begin : g_first
      assign v_in = c_valid;
      assign c_in = c_carry;
      assign t_in = ONE_Q30;
    end else begin : g_next
      assign v_in = b_valid[j-1];
      assign c_in = b_carry[j-1];
      assign t_in = b_t[j-1];
    end

    assign y_prod = 63'(c_in.x2) * 63'(t_in);
    assign m_prod = 65'(a_y[j]) * 65'(HORNER_MAGIC[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[j] <= 1'b0;
        b_valid[j] <= 1'b0;
      end else if (en) begin
        a_valid[j] <= v_in;
        b_valid[j] <= a_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_carry[j] <= c_in;
        a_y[j] <= y_prod[61:30];
        b_carry[j] <= a_carry[j];
        b_t[j] <= ONE_Q30 - 31'(m_prod >> HORNER_SHIFT[j]);
      end
    end
  end

endmodule

// ----- hdl/hhc_div_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, for the sinc term.
// Depends on hhc_pkg.
module hhc_div_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [hhc_pkg::NUM_W-1:0]  num,
  input  logic [hhc_pkg::DIV_DW-1:0] den,
  input  hhc_pkg::tap_side_t     in_side,
  output logic                  out_valid,
  output logic [hhc_pkg::DIV_QBITS-1:0] quot,
  output hhc_pkg::tap_side_t     out_side
);
  import hhc_pkg::*;

  logic                 sv [DIV_QBITS];
  tap_side_t            sside [DIV_QBITS];
  logic [DIV_DW-1:0]    srem [DIV_QBITS];
  logic [DIV_QBITS-1:0] slow [DIV_QBITS];
  logic [DIV_QBITS-1:0] squo [DIV_QBITS];
  logic [DIV_DW-1:0]    sden [DIV_QBITS];

  for (genvar i = 0; i < DIV_QBITS; i++) begin : g_stage
    logic                 v_in;
    tap_side_t            side_in;
    logic [DIV_DW-1:0]    rem_in;
    logic [DIV_QBITS-1:0] low_in;
    logic [DIV_QBITS-1:0] quo_in;
    logic [DIV_DW-1:0]    den_in;
    logic [DIV_DW:0]      shifted;
    logic                 ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign side_in = in_side;
      assign rem_in = DIV_DW'(num[NUM_W-1:DIV_QBITS]);
      assign low_in = num[DIV_QBITS-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign v_in = sv[i-1];
      assign side_in = sside[i-1];
      assign rem_in = srem[i-1];
      assign low_in = slow[i-1];
      assign quo_in = squo[i-1];
      assign den_in = sden[i-1];
    end

    // Shift in one numerator bit, subtract when it fits
    assign shifted = {rem_in, low_in[DIV_QBITS-1]};
    assign ge = shifted >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside[i] <= side_in;
        srem[i] <= ge ? DIV_DW'(shifted - {1'b0, den_in}) : shifted[DIV_DW-1:0];
        slow[i] <= low_in << 1;
        squo[i] <= {quo_in[DIV_QBITS-2:0], ge};
        sden[i] <= den_in;
      end
    end
  end

  assign out_valid = sv[DIV_QBITS-1];
  assign quot = squo[DIV_QBITS-1];
  assign out_side = sside[DIV_QBITS-1];

endmodule

// ----- hdl/hhc_scale.sv -----
`timescale 1ns / 1ps
// Tap value selection, window multiply, rounding, saturation and output register.
// Depends on hhc_pkg and hhc_out_if.
module hhc_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  hhc_pkg::tap_side_t    in_side,
  input  logic [hhc_pkg::DIV_QBITS-1:0] quot,
  hhc_out_if.source            tap_ch,
  output logic                 advance
);
  import hhc_pkg::*;

  logic        h_valid;
  logic [30:0] h_mag;
  logic        h_neg;
  tap_side_t   h_side;
  logic        m_valid;
  logic [61:0] m_prod;
  logic        m_neg;
  logic [5:0]  m_n;
  logic        m_last;
  logic [61:0] rsum;
  logic [16:0] r;
  logic [15:0] coeff_next;

  // Pipeline moves whenever the output register is free or being drained
  assign advance = !tap_ch.valid || tap_ch.ready;

  // Round half away from zero, then saturate to Q1.15
  always_comb begin
    rsum = m_prod + (62'd1 << 44);
    r = rsum[61:45];
    if (m_neg) begin
      coeff_next = (r > 17'd32768) ? 16'h8000 : 16'(17'd0 - r);
    end else begin
      coeff_next = (r > 17'd32767) ? 16'h7fff : r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      m_valid <= 1'b0;
      tap_ch.valid <= 1'b0;
    end else if (advance) begin
      h_valid <= in_valid;
      m_valid <= h_valid;
      tap_ch.valid <= m_valid;
    end
  end

  // Pick centre value or sinc quotient, multiply by window, register output word
  always_ff @(posedge clk) begin
    if (advance) begin
      h_mag <= in_side.centre ? in_side.hc : 31'(quot);
      h_neg <= !in_side.centre && !in_side.neg;
      h_side <= in_side;
      m_prod <= 62'(h_mag) * 62'(h_side.win);
      m_neg <= h_neg;
      m_n <= h_side.n;
      m_last <= h_side.last;
      tap_ch.tap_index <= m_n;
      tap_ch.coefficient <= coeff_next;
      tap_ch.last_tap <= m_last;
    end
  end

endmodule

// ----- tb/sv/hhc_coef_checker.sv -----
`timescale 1ns / 1ps
// Watches the cutoff and coefficient channels, predicts every coefficient set
// and compares it word by word. Depends on hhc_pkg.
module hhc_coef_checker #(
  parameter int TAPS = hhc_pkg::TAPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [17:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [16:0]        cutoff_hz,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         tap_index,
  input  logic signed [15:0] coefficient,
  input  logic               last_tap,
  output int                 errors,
  output int                 pending
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [15:0] coef;
    logic               last;
  } tap_word_t;

  localparam u64_t ONE = 64'd1073741824;
  localparam u64_t PI = 64'd3373259426;
  localparam u64_t WIN_A = 64'd579820585;
  localparam u64_t WIN_B = 64'd493921239;

  tap_word_t   taps_due[$];
  logic [17:0] rate_hz;

  // Sine of a 32-bit phase in Q2.30, Taylor series on a folded angle
  function automatic longint phase_sine(input logic [31:0] p);
    u64_t a;
    u64_t x;
    u64_t x2;
    u64_t t;
    u64_t s;
    a = p[31] ? (64'h1_0000_0000 - u64_t'(p)) : u64_t'(p);
    if (a > 64'h4000_0000) begin
      a = 64'h8000_0000 - a;
    end
    x = (a * PI) >> 31;
    x2 = (x * x) >> 30;
    t = ONE;
    t = ONE - ((x2 * t) >> 30) / 110;
    t = ONE - ((x2 * t) >> 30) / 72;
    t = ONE - ((x2 * t) >> 30) / 42;
    t = ONE - ((x2 * t) >> 30) / 20;
    t = ONE - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    return p[31] ? -longint'(s) : longint'(s);
  endfunction

  // Queue the full windowed high-pass set for one cutoff
  task automatic queue_coef_set(input logic [16:0] cut);
    u64_t      cut2;
    u64_t      sr;
    u64_t      fc;
    u64_t      k;
    u64_t      sm;
    u64_t      d;
    u64_t      q;
    u64_t      wp;
    u64_t      cm;
    u64_t      hm;
    u64_t      wm;
    u64_t      r;
    longint    h;
    longint    s;
    longint    c;
    longint    cw;
    longint    w;
    longint    y;
    int        mid;
    tap_word_t tw;
    cut2 = u64_t'(cut) * 2;
    sr = u64_t'(rate_hz);
    if (sr == 0) fc = 0;
    else if (cut2 >= sr) fc = ONE;
    else fc = ((cut2 << 30) + sr / 2) / sr;
    mid = (TAPS - 1) / 2;
    for (int n = 0; n < TAPS; n++) begin
      if (n == mid) begin
        h = longint'(ONE) - longint'(fc);
      end else begin
        k = u64_t'(n > mid ? n - mid : mid - n);
        s = phase_sine(32'((k * fc * 2) & 64'hFFFF_FFFF));
        sm = s < 0 ? u64_t'(-s) : u64_t'(s);
        d = PI * k;
        q = ((sm << 30) + d / 2) / d;
        h = s < 0 ? longint'(q) : -longint'(q);
      end
      wp = (((u64_t'(n) << 32) + u64_t'(TAPS - 1) / 2) / u64_t'(TAPS - 1)
            + 64'h4000_0000) & 64'hFFFF_FFFF;
      c = phase_sine(32'(wp));
      cm = c < 0 ? u64_t'(-c) : u64_t'(c);
      cw = longint'((cm * WIN_B + (64'd1 << 29)) >> 30);
      w = c < 0 ? longint'(WIN_A) + cw : longint'(WIN_A) - cw;
      hm = h < 0 ? u64_t'(-h) : u64_t'(h);
      wm = w < 0 ? u64_t'(-w) : u64_t'(w);
      r = (hm * wm + (64'd1 << 44)) >> 45;
      if ((h < 0) != (w < 0)) y = r > 32768 ? -32768 : -longint'(r);
      else y = r > 32767 ? 32767 : longint'(r);
      tw.idx = 6'(n);
      tw.coef = 16'(y);
      tw.last = (n == TAPS - 1);
      taps_due.push_back(tw);
    end
  endtask

  assign pending = taps_due.size();

  // Track the rate register, predict on accepted cutoffs, compare coefficients
  always @(posedge clk) begin
    tap_word_t exp_w;
    if (rst) begin
      rate_hz = hhc_pkg::FS_RESET;
      taps_due.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready) begin
        queue_coef_set(cutoff_hz);
      end
      if (out_valid && out_ready) begin
        if (taps_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("ERROR: unexpected word tap=%0d coef=%0d last=%0b",
                     tap_index, coefficient, last_tap);
          end
        end else begin
          exp_w = taps_due.pop_front();
          if (exp_w.idx !== tap_index || exp_w.coef !== coefficient
              || exp_w.last !== last_tap) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("ERROR: expected tap=%0d coef=%0d last=%0b, got tap=%0d coef=%0d last=%0b",
                       exp_w.idx, exp_w.coef, exp_w.last, tap_index, coefficient, last_tap);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        rate_hz = cfg_wr_data;
      end
    end
  end

endmodule

// ----- tb/sv/tb_hamming_highpass_coefficient_generator.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, rate writes, cutoff words and output stalls.
// Depends on hhc_pkg, hhc_if, the generator and hhc_coef_checker.
module tb_hamming_highpass_coefficient_generator;

  localparam int TAPS = hhc_pkg::TAPS_DEFAULT;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [17:0] cfg_wr_data;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          stall_left;
  bit          calm;

  hhc_in_if  cutoff_ch ();
  hhc_out_if tap_ch ();

  hamming_highpass_coefficient_generator #(.TAPS(TAPS)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cutoff_ch   (cutoff_ch),
    .tap_ch      (tap_ch)
  );

  hhc_coef_checker #(.TAPS(TAPS)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (cutoff_ch.valid),
    .in_ready    (cutoff_ch.ready),
    .cutoff_hz   (cutoff_ch.cutoff_hz),
    .out_valid   (tap_ch.valid),
    .out_ready   (tap_ch.ready),
    .tap_index   (tap_ch.tap_index),
    .coefficient (tap_ch.coefficient),
    .last_tap    (tap_ch.last_tap),
    .errors      (errors),
    .pending     (pending)
  );

  // Clock
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the coefficient channel at random
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      tap_ch.ready <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      tap_ch.ready <= 0;
    end else begin
      tap_ch.ready <= 1;
      if ($urandom_range(0, 5) == 0) stall_left <= gap_len();
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_cutoff(input logic [16:0] c);
    int g;
    g = gap_len();
    if (g > 0) begin
      cutoff_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    cutoff_ch.valid <= 1;
    cutoff_ch.cutoff_hz <= c;
    do @(posedge clk); while (!cutoff_ch.ready);
  endtask

  // Drain every outstanding word, then write a new rate
  task automatic set_rate(input logic [17:0] r);
    cutoff_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_items(input int count);
    logic [16:0] c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: c = 17'($urandom_range(0, 131071));
        1: c = 17'($urandom_range(0, 300));
        default: c = 17'($urandom_range(0, 24000));
      endcase
      send_cutoff(c);
    end
  endtask

  initial begin
    logic [17:0] rates [6];
    rates = '{18'd8000, 18'd192000, 18'd48000, 18'd0, 18'd262143, 18'd44100};
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    cutoff_ch.valid = 0;
    cutoff_ch.cutoff_hz = 0;
    calm = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset rate: edges of the cutoff range and the half-rate boundary
    send_cutoff(17'd0);
    send_cutoff(17'd1);
    send_cutoff(17'd22049);
    send_cutoff(17'd22050);
    send_cutoff(17'd22051);
    send_cutoff(17'd131071);
    send_cutoff(17'd65535);
    send_cutoff(17'd1000);
    random_items(12);

    // Walk the rate through its extremes, zero included
    foreach (rates[i]) begin
      set_rate(rates[i]);
      calm = (i == 2);
      send_cutoff(17'd0);
      send_cutoff(17'(rates[i] / 2));
      send_cutoff(17'd131071);
      random_items(12);
    end
    calm = 0;
    cutoff_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
